// ===== hdl/cmas_pkg.sv =====
// Shared types for the centred moving-average smoother.
package cmas_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DRAIN,
    ST_DIV,
    ST_EMIT,
    ST_FRD,
    ST_FWT
  } cmas_state_t;

endpackage

// ===== hdl/cmas_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module cmas_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/centered_moving_average_smoother.sv =====
// Centred moving-average smoother: serial window sum and restoring divider.
// Takes one word at a time. Edge point: one window read of the centre word, drain and emit;
// interior point: 2h+1 window reads, 1 drain, SUM_W-1 divider steps and emit. Word with no
// result: stays idle. Final word adds a window read, a wait and an emit per flushed point.
// Paced by the single window RAM read port and the one-bit-per-cycle divider. Reset
// (synchronous, rst_n low): idle, counts cleared, half width 1; window RAM not cleared.
module centered_moving_average_smoother
  import cmas_pkg::*;
#(
  parameter int MAX_HALF   = 15,
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [3:0]                   cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_point_x,
  input  logic signed [COORD_BITS-1:0] in_point_y,
  input  logic                         in_is_final,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] out_x,
  output logic signed [COORD_BITS-1:0] out_y,
  output logic                         out_final
);

  localparam int WIN_DEPTH = 2 * MAX_HALF + 2;
  localparam int AW        = $clog2(WIN_DEPTH);
  localparam int HW        = $clog2(MAX_HALF + 1);
  localparam int DW        = $clog2(WIN_DEPTH);
  localparam int NW        = $clog2(WIN_DEPTH) + 1;
  localparam int SUM_W     = COORD_BITS + $clog2(WIN_DEPTH);
  localparam int MAG_W     = SUM_W - 1;
  localparam int CW        = $clog2(MAG_W);
  localparam logic [NW-1:0] N_MAX = '1;

  cmas_state_t state_r, state_nxt;

  logic [3:0]                   cfg_hw_r;
  logic [AW-1:0]                wr_ptr_r, wr_ptr_nxt;
  logic [NW-1:0]                n_r, n_nxt;
  logic [AW-1:0]                newest_r, newest_nxt;
  logic                         fin_r, fin_nxt;
  logic [HW-1:0]                h_r, h_nxt;
  logic                         interior_r, interior_nxt;
  logic [HW-1:0]                rr_r, rr_nxt;
  logic [AW-1:0]                b_r, b_nxt;
  logic [AW-1:0]                blast_r, blast_nxt;
  logic [AW-1:0]                bd_r, bd_nxt;
  logic                         rd_vld_r, rd_vld_nxt;
  logic signed [SUM_W-1:0]      acc_r, acc_nxt;
  logic [COORD_BITS-1:0]        cen_x_r, cen_x_nxt;
  logic [COORD_BITS-1:0]        res_y_r, res_y_nxt;
  logic [DW-1:0]                rem_r, rem_nxt;
  logic [MAG_W-1:0]             quo_r, quo_nxt;
  logic                         neg_r, neg_nxt;
  logic [CW-1:0]                div_cnt_r, div_cnt_nxt;
  logic                         flush_r, flush_nxt;
  logic [HW-1:0]                r_r, r_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [COORD_BITS-1:0]        out_x_r, out_x_nxt;
  logic [COORD_BITS-1:0]        out_y_r, out_y_nxt;
  logic                         out_final_r, out_final_nxt;

  logic                         accept;
  logic [HW-1:0]                h_eff;
  logic [NW-1:0]                n_inc;
  logic [AW-1:0]                back;
  logic [AW-1:0]                rd_addr;
  logic [2*COORD_BITS-1:0]      rd_data;
  logic signed [COORD_BITS-1:0] y_rd;
  logic [COORD_BITS-1:0]        x_rd;
  logic signed [SUM_W-1:0]      sum_fin;
  logic signed [SUM_W-1:0]      sum_abs;
  logic [DW-1:0]                divisor;
  logic [DW:0]                  rem_sh;
  logic [DW:0]                  rem_diff;
  logic                         ge;
  logic [MAG_W-1:0]             quo_step;
  logic [MAG_W-1:0]             quo_signed;
  logic                         out_free;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign h_eff    = (32'(cfg_hw_r) > MAX_HALF) ? HW'(MAX_HALF) : HW'(cfg_hw_r);
  assign n_inc    = (n_r == N_MAX) ? n_r : n_r + NW'(1);

  assign back    = (state_r == ST_FRD) ? (AW'(r_r) - AW'(1)) : b_r;
  assign rd_addr = (newest_r >= back) ? (newest_r - back)
                                      : AW'(32'(newest_r) + WIN_DEPTH - 32'(back));

  cmas_ram #(
    .WIDTH(2 * COORD_BITS),
    .DEPTH(WIN_DEPTH)
  ) u_win (
    .clk  (clk),
    .we   (accept),
    .waddr(wr_ptr_r),
    .wdata({in_point_x, in_point_y}),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  assign x_rd    = rd_data[2*COORD_BITS-1:COORD_BITS];
  assign y_rd    = signed'(rd_data[COORD_BITS-1:0]);
  assign sum_fin = acc_r + SUM_W'(y_rd);
  assign sum_abs = sum_fin[SUM_W-1] ? -sum_fin : sum_fin;

  assign divisor    = {h_r, 1'b1};
  assign rem_sh     = {rem_r, quo_r[MAG_W-1]};
  assign rem_diff   = rem_sh - {1'b0, divisor};
  assign ge         = (rem_sh >= {1'b0, divisor});
  assign quo_step   = {quo_r[MAG_W-2:0], ge};
  assign quo_signed = neg_r ? (~quo_step + MAG_W'(1)) : quo_step;

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cfg_hw_r    <= 4'd1;
      wr_ptr_r    <= '0;
      n_r         <= '0;
      rd_vld_r    <= 1'b0;
      flush_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      n_r         <= n_nxt;
      rd_vld_r    <= rd_vld_nxt;
      flush_r     <= flush_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cfg_hw_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    newest_r    <= newest_nxt;
    fin_r       <= fin_nxt;
    h_r         <= h_nxt;
    interior_r  <= interior_nxt;
    rr_r        <= rr_nxt;
    b_r         <= b_nxt;
    blast_r     <= blast_nxt;
    bd_r        <= bd_nxt;
    acc_r       <= acc_nxt;
    cen_x_r     <= cen_x_nxt;
    res_y_r     <= res_y_nxt;
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    neg_r       <= neg_nxt;
    div_cnt_r   <= div_cnt_nxt;
    r_r         <= r_nxt;
    out_x_r     <= out_x_nxt;
    out_y_r     <= out_y_nxt;
    out_final_r <= out_final_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    wr_ptr_nxt    = wr_ptr_r;
    n_nxt         = n_r;
    newest_nxt    = newest_r;
    fin_nxt       = fin_r;
    h_nxt         = h_r;
    interior_nxt  = interior_r;
    rr_nxt        = rr_r;
    b_nxt         = b_r;
    blast_nxt     = blast_r;
    bd_nxt        = bd_r;
    rd_vld_nxt    = 1'b0;
    acc_nxt       = acc_r;
    cen_x_nxt     = cen_x_r;
    res_y_nxt     = res_y_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    neg_nxt       = neg_r;
    div_cnt_nxt   = div_cnt_r;
    flush_nxt     = flush_r;
    r_nxt         = r_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_final_nxt = out_final_r;

    // accumulate window and pick out the centre word
    if (rd_vld_r) begin
      if (interior_r) begin
        acc_nxt = sum_fin;
      end
      if (bd_r == AW'(h_r)) begin
        cen_x_nxt = x_rd;
        res_y_nxt = y_rd;
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          newest_nxt   = wr_ptr_r;
          wr_ptr_nxt   = (32'(wr_ptr_r) == WIN_DEPTH - 1) ? '0 : wr_ptr_r + AW'(1);
          fin_nxt      = in_is_final;
          h_nxt        = h_eff;
          n_nxt        = in_is_final ? '0 : n_inc;
          interior_nxt = (32'(n_inc) >= 2 * 32'(h_eff) + 1);
          rr_nxt       = (32'(n_inc) < 32'(h_eff)) ? HW'(n_inc) : h_eff;
          flush_nxt    = 1'b0;
          acc_nxt      = '0;
          if (32'(n_inc) > 32'(h_eff)) begin
            if (32'(n_inc) >= 2 * 32'(h_eff) + 1) begin
              b_nxt     = '0;
              blast_nxt = AW'({h_eff, 1'b0});
            end else begin
              b_nxt     = AW'(h_eff);
              blast_nxt = AW'(h_eff);
            end
            state_nxt = ST_SUM;
          end else if (in_is_final) begin
            flush_nxt = 1'b1;
            r_nxt     = HW'(n_inc);
            state_nxt = ST_FRD;
          end
        end
      end
      ST_SUM: begin
        rd_vld_nxt = 1'b1;
        bd_nxt     = b_r;
        b_nxt      = b_r + AW'(1);
        if (b_r == blast_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (interior_r) begin
          neg_nxt     = sum_fin[SUM_W-1];
          quo_nxt     = sum_abs[MAG_W-1:0];
          rem_nxt     = '0;
          div_cnt_nxt = '0;
          state_nxt   = ST_DIV;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_DIV: begin
        rem_nxt     = ge ? rem_diff[DW-1:0] : rem_sh[DW-1:0];
        quo_nxt     = quo_step;
        div_cnt_nxt = div_cnt_r + CW'(1);
        if (32'(div_cnt_r) == MAG_W - 1) begin
          res_y_nxt = quo_signed[COORD_BITS-1:0];
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = cen_x_r;
          out_y_nxt     = res_y_r;
          out_final_nxt = flush_r ? (r_r == HW'(1)) : (fin_r && (h_r == '0));
          if (flush_r) begin
            if (r_r == HW'(1)) begin
              flush_nxt = 1'b0;
              state_nxt = ST_IDLE;
            end else begin
              r_nxt     = r_r - HW'(1);
              state_nxt = ST_FRD;
            end
          end else if (fin_r && (rr_r != '0)) begin
            flush_nxt = 1'b1;
            r_nxt     = rr_r;
            state_nxt = ST_FRD;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_FRD: begin
        state_nxt = ST_FWT;
      end
      ST_FWT: begin
        cen_x_nxt = x_rd;
        res_y_nxt = y_rd;
        state_nxt = ST_EMIT;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_x     = signed'(out_x_r);
  assign out_y     = signed'(out_y_r);
  assign out_final = out_final_r;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_x_r) && $stable(out_y_r)
                                     && $stable(out_final_r)))
    else $error("result word changed while stalled");

  a_rd_vld_in_sum: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r == ST_SUM || state_r == ST_DRAIN))
    else $error("window read data outside summing");

  a_flush_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FRD || state_r == ST_FWT) |-> (flush_r && r_r != '0))
    else $error("flush without points left");

  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (32'(div_cnt_r) < MAG_W))
    else $error("divider step count overrun");

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && out_free) |=> out_valid_r)
    else $error("result word not loaded");

endmodule
